// ===== design/vcsd_pkg.sv =====
// Package for the vehicle CAN signal decoder.
// Holds identifiers, the command handed from front to back, and decode helpers.
// No dependencies; every other design file imports it.
package vcsd_pkg;

   localparam logic [28:0] ID_COOLANT  = 29'h488;
   localparam logic [28:0] ID_CLOCK    = 29'h552;
   localparam logic [28:0] ID_LAMPS    = 29'h517;
   localparam logic [28:0] ID_SPOILER  = 29'h612;
   localparam logic [28:0] ID_PRESSURE = 29'h7E8;

   localparam int unsigned DAY_SECONDS  = 86400;
   localparam int unsigned CLOCK_SHIFT  = DAY_SECONDS - 43200 + 510;
   localparam int unsigned CLOCK_QUOT_MAX = 12;

   localparam logic [7:0] LAMP_ON_B0  = 8'hEB;
   localparam logic [7:0] LAMP_ON_B1  = 8'h7A;
   localparam logic [7:0] LAMP_OFF_B0 = 8'h69;
   localparam logic [7:0] LAMP_OFF_B1 = 8'h5A;
   localparam logic [7:0] LAMP_B2     = 8'h80;

   localparam logic [7:0] OBD_LEN_BYTE = 8'h03;
   localparam logic [7:0] OBD_MODE_ACK = 8'h41;
   localparam logic [7:0] OBD_PID_MAP  = 8'h0B;

   localparam logic [7:0] COOLANT_OFFSET = 8'd40;
   localparam logic [7:0] ATM_RESET      = 8'd101;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [6:0] SPOILER_CLOSED = 7'd0;
   localparam logic [6:0] SPOILER_LOW    = 7'd30;
   localparam logic [6:0] SPOILER_MID    = 7'd80;
   localparam logic [6:0] SPOILER_FULL   = 7'd100;

   typedef enum logic [2:0] {
      CMD_IGNORE,
      CMD_COUNT,
      CMD_COOLANT,
      CMD_CLOCK,
      CMD_LAMPS,
      CMD_SPOILER,
      CMD_PRESSURE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [20:0]  value;
      logic [3:0]   quot;
      logic [31:0]  arrival;
   } cmd_type;

   function automatic logic [6:0] spoiler_bucket(input logic [7:0] b);
      logic [6:0] pct;
      if (b <= 8'h10) begin
         pct = SPOILER_CLOSED;
      end else if (b >= 8'h50) begin
         pct = SPOILER_FULL;
      end else if (b <= 8'h20) begin
         pct = SPOILER_LOW;
      end else if (b <= 8'h40) begin
         pct = SPOILER_MID;
      end else begin
         pct = SPOILER_FULL;
      end
      return pct;
   endfunction

   // Whole days contained in the shifted clock value; the compares are independent.
   function automatic logic [3:0] clock_quotient(input logic [20:0] sum);
      logic [3:0] q;
      q = '0;
      for (int k = 1; k <= CLOCK_QUOT_MAX; k++) begin
         if (sum >= 21'(k * DAY_SECONDS)) begin
            q = 4'(k);
         end
      end
      return q;
   endfunction

   function automatic logic [20:0] day_multiple(input logic [3:0] q);
      logic [20:0] m;
      m = '0;
      for (int k = 1; k <= CLOCK_QUOT_MAX; k++) begin
         if (q == 4'(k)) begin
            m = 21'(k * DAY_SECONDS);
         end
      end
      return m;
   endfunction

endpackage

// ===== design/vcsd_ifs.sv =====
// Channel interfaces of the vehicle CAN signal decoder: frame, result and register write.
// Depends on vcsd_pkg only through the import in each header.
interface vcsd_req_if import vcsd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [28:0] frame_id;
   logic        is_extended;
   logic        is_remote;
   logic [3:0]  data_length;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;
   logic [7:0]  byte4;
   logic [31:0] arrival_ms;

   modport source (
      output valid, frame_id, is_extended, is_remote, data_length,
             byte0, byte1, byte2, byte3, byte4, arrival_ms,
      input  ready
   );
   modport sink (
      input  valid, frame_id, is_extended, is_remote, data_length,
             byte0, byte1, byte2, byte3, byte4, arrival_ms,
      output ready
   );
endinterface

interface vcsd_rsp_if import vcsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              was_decoded;
   logic signed [8:0] coolant_c;
   logic [16:0]       time_of_day_s;
   logic              clock_valid;
   logic              lamps_lit;
   logic              lamps_valid;
   logic [6:0]        spoiler_pct;
   logic signed [8:0] boost_kpa;
   logic              pressure_valid;
   logic [31:0]       total_frames;
   logic [31:0]       decoded_frames;
   logic [31:0]       last_decode_ms;

   modport source (
      output valid, was_decoded, coolant_c, time_of_day_s, clock_valid, lamps_lit,
             lamps_valid, spoiler_pct, boost_kpa, pressure_valid, total_frames,
             decoded_frames, last_decode_ms,
      input  ready
   );
   modport sink (
      input  valid, was_decoded, coolant_c, time_of_day_s, clock_valid, lamps_lit,
             lamps_valid, spoiler_pct, boost_kpa, pressure_valid, total_frames,
             decoded_frames, last_decode_ms,
      output ready
   );
endinterface

interface vcsd_csr_if import vcsd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== design/vehicle_can_signal_decoder_core.sv =====
// Vehicle CAN signal decoder. Each received frame yields exactly one result that
// shows the decoded signal state after that frame. A frame is accepted every cycle
// while the command queue has room; its result is held in the queue and then in the
// back-end output registers, and a stalled result only fills the queue, sized by QUEUE_DEPTH.
// The pressure register write port is always ready and must be used while idle.
module vehicle_can_signal_decoder_core import vcsd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   vcsd_req_if.sink   req_ch,
   vcsd_rsp_if.source rsp_ch,
   vcsd_csr_if.sink   csr_ch
);

   logic [7:0] atm_ff, atm_in;
   logic       push_valid;
   logic       push_ready;
   cmd_type    push_cmd;
   logic       pop_valid;
   logic       pop_ready;
   cmd_type    pop_cmd;

   assign csr_ch.ready = 1'b1;
   assign atm_in       = csr_ch.valid ? csr_ch.data : atm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         atm_ff <= ATM_RESET;
      end else begin
         atm_ff <= atm_in;
      end
   end

   vcsd_front u_front (
      .req_ch          (req_ch),
      .atmospheric_kpa (atm_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   vcsd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   vcsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.time_of_day_s < 17'(DAY_SECONDS))
      else $error("Decoded clock is outside one day.");

   a_spoiler_bucket: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.spoiler_pct == SPOILER_CLOSED || rsp_ch.spoiler_pct == SPOILER_LOW ||
      rsp_ch.spoiler_pct == SPOILER_MID || rsp_ch.spoiler_pct == SPOILER_FULL)
      else $error("Spoiler position is not a bucket value.");

   a_lamps_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.lamps_lit |-> rsp_ch.lamps_valid)
      else $error("Lamps lit without a recognized lamp pattern.");

   a_boost_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.pressure_valid |-> (rsp_ch.boost_kpa == 9'sd0))
      else $error("Boost changed before any pressure reply.");
`endif

endmodule

// ===== design/vcsd_front.sv =====
// Front end of the vehicle CAN signal decoder: classifies each frame into a command.
// Depends on vcsd_pkg and vcsd_req_if.
module vcsd_front import vcsd_pkg::*; (
   vcsd_req_if.sink   req_ch,
   input  logic [7:0] atmospheric_kpa,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_cmd
);

   logic [20:0] clock_sum;
   logic        lamp_on_match;
   logic        lamp_off_match;
   logic        obd_match;

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      clock_sum = 21'({req_ch.byte0, req_ch.byte1, req_ch.byte2[7:4]})
                  + 21'(CLOCK_SHIFT);
      lamp_on_match  = (req_ch.byte0 == LAMP_ON_B0) && (req_ch.byte1 == LAMP_ON_B1)
                       && (req_ch.byte2 == LAMP_B2);
      lamp_off_match = (req_ch.byte0 == LAMP_OFF_B0) && (req_ch.byte1 == LAMP_OFF_B1)
                       && (req_ch.byte2 == LAMP_B2);
      obd_match      = (req_ch.byte0 == OBD_LEN_BYTE) && (req_ch.byte1 == OBD_MODE_ACK)
                       && (req_ch.byte2 == OBD_PID_MAP);

      push_cmd.kind    = CMD_COUNT;
      push_cmd.value   = '0;
      push_cmd.quot    = '0;
      push_cmd.arrival = req_ch.arrival_ms;

      priority if (req_ch.is_extended || req_ch.is_remote) begin
         push_cmd.kind = CMD_IGNORE;
      end else if (req_ch.frame_id == ID_COOLANT) begin
         if (req_ch.data_length >= 4'd1) begin
            push_cmd.kind  = CMD_COOLANT;
            push_cmd.value = 21'({1'b0, req_ch.byte0} - {1'b0, COOLANT_OFFSET});
         end
      end else if (req_ch.frame_id == ID_CLOCK) begin
         if (req_ch.data_length >= 4'd3) begin
            push_cmd.kind  = CMD_CLOCK;
            push_cmd.value = clock_sum;
            push_cmd.quot  = clock_quotient(clock_sum);
         end
      end else if (req_ch.frame_id == ID_LAMPS) begin
         if ((req_ch.data_length >= 4'd3) && (lamp_on_match || lamp_off_match)) begin
            push_cmd.kind  = CMD_LAMPS;
            push_cmd.value = 21'(lamp_on_match);
         end
      end else if (req_ch.frame_id == ID_SPOILER) begin
         if (req_ch.data_length >= 4'd5) begin
            push_cmd.kind  = CMD_SPOILER;
            push_cmd.value = 21'(spoiler_bucket(req_ch.byte4));
         end
      end else if (req_ch.frame_id == ID_PRESSURE) begin
         if ((req_ch.data_length >= 4'd4) && obd_match) begin
            push_cmd.kind  = CMD_PRESSURE;
            push_cmd.value = 21'({1'b0, req_ch.byte3} - {1'b0, atmospheric_kpa});
         end
      end else begin
         push_cmd.kind = CMD_COUNT;
      end
   end

endmodule

// ===== design/vcsd_queue.sv =====
// Command queue between the front end and the back end of the decoder.
// Depends on vcsd_pkg for the command type.
module vcsd_queue import vcsd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = $clog2(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic            push;
   logic            pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/vcsd_back.sv =====
// Back end of the decoder: applies commands to the signal state and drives results.
// Depends on vcsd_pkg and vcsd_rsp_if.
module vcsd_back import vcsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  cmd_type    pop_cmd,
   vcsd_rsp_if.source rsp_ch
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        hit_ff, hit_in;
   logic [8:0]  coolant_ff, coolant_in;
   logic [16:0] clock_ff, clock_in;
   logic        clock_seen_ff, clock_seen_in;
   logic        lamps_on_ff, lamps_on_in;
   logic        lamps_seen_ff, lamps_seen_in;
   logic [6:0]  spoiler_ff, spoiler_in;
   logic [8:0]  boost_ff, boost_in;
   logic        pressure_seen_ff, pressure_seen_in;
   logic [31:0] received_ff, received_in;
   logic [31:0] decoded_ff, decoded_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [20:0] clock_rem;
   logic        pop;

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop       = pop_valid && pop_ready;
   assign clock_rem = pop_cmd.value - day_multiple(pop_cmd.quot);

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      hit_in           = hit_ff;
      coolant_in       = coolant_ff;
      clock_in         = clock_ff;
      clock_seen_in    = clock_seen_ff;
      lamps_on_in      = lamps_on_ff;
      lamps_seen_in    = lamps_seen_ff;
      spoiler_in       = spoiler_ff;
      boost_in         = boost_ff;
      pressure_seen_in = pressure_seen_ff;
      received_in      = received_ff;
      decoded_in       = decoded_ff;
      last_time_in     = last_time_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         hit_in       = 1'b0;
         if (pop_cmd.kind != CMD_IGNORE) begin
            received_in = received_ff + 32'd1;
         end
         unique case (pop_cmd.kind)
            CMD_COOLANT: begin
               coolant_in = pop_cmd.value[8:0];
               hit_in     = 1'b1;
            end
            CMD_CLOCK: begin
               clock_in      = clock_rem[16:0];
               clock_seen_in = 1'b1;
               hit_in        = 1'b1;
            end
            CMD_LAMPS: begin
               lamps_on_in   = pop_cmd.value[0];
               lamps_seen_in = 1'b1;
               hit_in        = 1'b1;
            end
            CMD_SPOILER: begin
               spoiler_in = pop_cmd.value[6:0];
               hit_in     = 1'b1;
            end
            CMD_PRESSURE: begin
               boost_in         = pop_cmd.value[8:0];
               pressure_seen_in = 1'b1;
               hit_in           = 1'b1;
            end
            default: begin
               hit_in = 1'b0;
            end
         endcase
         if (hit_in) begin
            decoded_in   = decoded_ff + 32'd1;
            last_time_in = pop_cmd.arrival;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         hit_ff           <= 1'b0;
         coolant_ff       <= '0;
         clock_ff         <= '0;
         clock_seen_ff    <= 1'b0;
         lamps_on_ff      <= 1'b0;
         lamps_seen_ff    <= 1'b0;
         spoiler_ff       <= '0;
         boost_ff         <= '0;
         pressure_seen_ff <= 1'b0;
         received_ff      <= '0;
         decoded_ff       <= '0;
         last_time_ff     <= '0;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         hit_ff           <= hit_in;
         coolant_ff       <= coolant_in;
         clock_ff         <= clock_in;
         clock_seen_ff    <= clock_seen_in;
         lamps_on_ff      <= lamps_on_in;
         lamps_seen_ff    <= lamps_seen_in;
         spoiler_ff       <= spoiler_in;
         boost_ff         <= boost_in;
         pressure_seen_ff <= pressure_seen_in;
         received_ff      <= received_in;
         decoded_ff       <= decoded_in;
         last_time_ff     <= last_time_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.was_decoded    = hit_ff;
   assign rsp_ch.coolant_c      = $signed(coolant_ff);
   assign rsp_ch.time_of_day_s  = clock_ff;
   assign rsp_ch.clock_valid    = clock_seen_ff;
   assign rsp_ch.lamps_lit      = lamps_on_ff;
   assign rsp_ch.lamps_valid    = lamps_seen_ff;
   assign rsp_ch.spoiler_pct    = spoiler_ff;
   assign rsp_ch.boost_kpa      = $signed(boost_ff);
   assign rsp_ch.pressure_valid = pressure_seen_ff;
   assign rsp_ch.total_frames   = received_ff;
   assign rsp_ch.decoded_frames = decoded_ff;
   assign rsp_ch.last_decode_ms = last_time_ff;

endmodule
